@@ rtl/dmarf_pkg.sv @@
// Shared constants and types for the DMA controller register file.
// Holds access codes, register offsets and the control/status structs.
// No dependencies.
package dmarf_pkg;

  localparam int NUM_CHANNELS = 4;
  localparam int CH_W         = $clog2(NUM_CHANNELS);

  // Access codes carried by func.
  localparam logic [2:0] FUNC_READ_BYTE  = 3'd0;
  localparam logic [2:0] FUNC_WRITE_BYTE = 3'd1;
  localparam logic [2:0] FUNC_READ_HALF  = 3'd2;
  localparam logic [2:0] FUNC_WRITE_HALF = 3'd3;
  localparam logic [2:0] FUNC_DMA_REQ    = 3'd4;

  // Register offsets.
  localparam logic [3:0] OFF_SELECT   = 4'h1;
  localparam logic [3:0] OFF_COUNT_LO = 4'h2;
  localparam logic [3:0] OFF_COUNT_HI = 4'h3;
  localparam logic [3:0] OFF_ADDR_0   = 4'h4;
  localparam logic [3:0] OFF_ADDR_1   = 4'h5;
  localparam logic [3:0] OFF_ADDR_2   = 4'h6;
  localparam logic [3:0] OFF_ADDR_3   = 4'h7;
  localparam logic [3:0] OFF_DEV_CTRL = 4'h8;
  localparam logic [3:0] OFF_MODE     = 4'hA;

  // Device control bit that enables requests.
  localparam int DEV_CTRL_REQ_EN = 2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture a new item
    logic step;      // perform one byte step
    logic hi_phase;  // the step works on the second byte
  } dmarf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_half;   // the held item is a half-word access
  } dmarf_stat_t;

endpackage

@@ rtl/dmarf_ctrl.sv @@
// Sequencing controller of the DMA controller register file.
// Steps each item through one or two byte phases; uses dmarf_pkg.
module dmarf_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  dmarf_pkg::dmarf_stat_t stat,
  output dmarf_pkg::dmarf_cmd_t  cmd,
  output logic                  busy,
  output logic                  done
);
  import dmarf_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LO,
    ST_HI
  } state_t;

  state_t state;

  // Commands follow the state directly.
  always_comb begin
    cmd.load     = start && (state == ST_IDLE);
    cmd.step     = (state == ST_LO) || (state == ST_HI);
    cmd.hi_phase = (state == ST_HI);
  end

  assign busy = (state != ST_IDLE);

  // State register and the registered result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) state <= ST_LO;
        end
        ST_LO: begin
          if (stat.is_half) begin
            state <= ST_HI;
          end else begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end
        end
        ST_HI: begin
          state <= ST_IDLE;
          done  <= 1'b1;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/dmarf_datapath.sv @@
// Register storage, byte decode and result registers of the register file.
// Performs one byte access per step under controller command; uses dmarf_pkg.
module dmarf_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  dmarf_pkg::dmarf_cmd_t          cmd,
  output dmarf_pkg::dmarf_stat_t         stat,
  input  logic [2:0]                    func,
  input  logic [3:0]                    reg_offset,
  input  logic [15:0]                   write_data,
  input  logic [dmarf_pkg::CH_W-1:0]    req_channel,
  input  logic                          cfg_write,
  input  logic [dmarf_pkg::NUM_CHANNELS-1:0] cfg_data,
  output logic [15:0]                   read_data,
  output logic                          busy_res
);
  import dmarf_pkg::*;

  // Held item.
  logic [2:0]      func_q;
  logic [3:0]      offset_q;
  logic [15:0]     wdata_q;
  logic [CH_W-1:0] req_ch_q;

  // Register state.
  logic [NUM_CHANNELS-1:0] channel_mask;
  logic [7:0]  select_reg;
  logic [15:0] base_count      [NUM_CHANNELS];
  logic [15:0] current_count   [NUM_CHANNELS];
  logic [31:0] base_address    [NUM_CHANNELS];
  logic [31:0] current_address [NUM_CHANNELS];
  logic [7:0]  device_control;
  logic [7:0]  mode_control;
  logic        working;

  logic [CH_W-1:0] ch;
  logic            base_only;
  logic [3:0]      step_off;
  logic [7:0]      step_wbyte;
  logic [7:0]      rd_byte;
  logic [15:0]     cnt_sel;
  logic [31:0]     adr_sel;
  logic            is_read;
  logic            is_write;
  logic            do_write;

  assign stat.is_half = (func_q == FUNC_READ_HALF) || (func_q == FUNC_WRITE_HALF);
  assign is_read      = (func_q == FUNC_READ_BYTE) || (func_q == FUNC_READ_HALF);
  assign is_write     = (func_q == FUNC_WRITE_BYTE) || (func_q == FUNC_WRITE_HALF);
  assign do_write     = cmd.step && is_write;

  assign ch         = select_reg[CH_W-1:0];
  assign base_only  = select_reg[2];
  assign step_off   = cmd.hi_phase ? offset_q + 4'd1 : offset_q;
  assign step_wbyte = cmd.hi_phase ? wdata_q[15:8] : wdata_q[7:0];
  assign cnt_sel    = base_only ? base_count[ch] : current_count[ch];
  assign adr_sel    = base_only ? base_address[ch] : current_address[ch];

  // Byte read decode.
  always_comb begin
    unique case (step_off)
      OFF_SELECT:   rd_byte = {select_reg[5:2], 4'(1 << ch)};
      OFF_COUNT_LO: rd_byte = cnt_sel[7:0];
      OFF_COUNT_HI: rd_byte = cnt_sel[15:8];
      OFF_ADDR_0, OFF_ADDR_1, OFF_ADDR_2, OFF_ADDR_3:
                    rd_byte = adr_sel[8*step_off[1:0] +: 8];
      OFF_DEV_CTRL: rd_byte = device_control;
      OFF_MODE:     rd_byte = mode_control;
      default:      rd_byte = 8'h00;
    endcase
  end

  // Item capture; payload needs no reset.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q   <= func;
      offset_q <= reg_offset;
      wdata_q  <= write_data;
      req_ch_q <= req_channel;
    end
  end

  // Result register: cleared on capture, filled byte by byte on reads.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      read_data <= 16'h0000;
    end else if (cmd.step && is_read) begin
      if (cmd.hi_phase) read_data[15:8] <= rd_byte;
      else              read_data[7:0]  <= rd_byte;
    end
  end

  // Control registers, mask and the busy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_mask   <= '0;
      select_reg     <= 8'h00;
      device_control <= 8'h00;
      mode_control   <= 8'h00;
      working        <= 1'b0;
    end else begin
      if (cfg_write) channel_mask <= cfg_data;
      if (do_write) begin
        unique case (step_off)
          OFF_SELECT:   select_reg     <= step_wbyte;
          OFF_DEV_CTRL: device_control <= step_wbyte;
          OFF_MODE:     mode_control   <= step_wbyte;
          default:      ;
        endcase
      end
      if (cmd.step && (func_q == FUNC_DMA_REQ) && channel_mask[req_ch_q]
          && device_control[DEV_CTRL_REQ_EN]) begin
        working <= 1'b1;
      end
    end
  end

  // Per-channel counts and addresses. The top address byte always reaches the
  // current register; other bytes skip it in base-only mode.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        base_count[i]      <= 16'h0000;
        current_count[i]   <= 16'h0000;
        base_address[i]    <= 32'h0;
        current_address[i] <= 32'h0;
      end
    end else if (do_write) begin
      unique case (step_off)
        OFF_COUNT_LO: begin
          base_count[ch][7:0] <= step_wbyte;
          if (!base_only) current_count[ch][7:0] <= step_wbyte;
        end
        OFF_COUNT_HI: begin
          base_count[ch][15:8] <= step_wbyte;
          if (!base_only) current_count[ch][15:8] <= step_wbyte;
        end
        OFF_ADDR_0, OFF_ADDR_1, OFF_ADDR_2: begin
          base_address[ch][8*step_off[1:0] +: 8] <= step_wbyte;
          if (!base_only) current_address[ch][8*step_off[1:0] +: 8] <= step_wbyte;
        end
        OFF_ADDR_3: begin
          base_address[ch][31:24]    <= step_wbyte;
          current_address[ch][31:24] <= step_wbyte;
        end
        default: ;
      endcase
    end
  end

  assign busy_res = working;

endmodule

@@ rtl/dma_controller_register_file.sv @@
// Byte accesses and DMA requests: accepted in ST_IDLE, stepped in ST_LO, then the strobe.
// Half-word accesses add ST_HI for the second byte before the strobe.
// A new item is taken only in ST_IDLE, so not before the last one is through;
// busy is low again in the strobe cycle.
// Synchronous reset clears the register map, the channel mask, the busy flag and the strobe.
// Top level of the DMA controller register file; uses dmarf_pkg, dmarf_ctrl, dmarf_datapath.
module dma_controller_register_file (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        func,
  input  logic [3:0]                        reg_offset,
  input  logic [15:0]                       write_data,
  input  logic [dmarf_pkg::CH_W-1:0]        req_channel,
  output logic                              done,
  output logic [15:0]                       read_data,
  output logic                              busy_res,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dmarf_pkg::NUM_CHANNELS-1:0] cfg_data
);
  import dmarf_pkg::*;

  dmarf_cmd_t  cmd;
  dmarf_stat_t stat;

  // The mask is taken whenever no item is in progress.
  assign cfg_ready = !busy;

  dmarf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  dmarf_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .func        (func),
    .reg_offset  (reg_offset),
    .write_data  (write_data),
    .req_channel (req_channel),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .read_data   (read_data),
    .busy_res    (busy_res)
  );

endmodule

@@ rtl/dmarf_checker.sv @@
// Port-level checks for the DMA controller register file.
// Bound to dma_controller_register_file; uses only its ports.
module dmarf_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic busy_res
);

  // An accepted item always occupies the block for the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // A result strobe comes only when busy was high in the cycle before.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without preceding work");

  // The block is free in the cycle that shows a result.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("busy during result strobe");

  // Two results never stand in consecutive cycles.
  a_done_spacing: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("back-to-back result strobes");

  // Once set, the transfer flag holds until reset.
  a_busy_res_sticky: assert property (@(posedge clk) disable iff (rst)
    busy_res |=> busy_res)
    else $error("transfer flag cleared without reset");

endmodule

bind dma_controller_register_file dmarf_checker u_dmarf_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .busy_res (busy_res)
);
